/* hw/rtl/tagl_pkg.sv */
package tagl_pkg;

   // default geometry: 8 ways, 64 sets, 128-byte lines, 32-bit addresses
   localparam int unsigned DefWaysLog2      = 3;
   localparam int unsigned DefLineBytesLog2 = 7;
   localparam int unsigned DefSetsLog2      = 6;
   localparam int unsigned DefAddrBits      = 32;

   // fixed widths of the result fields
   localparam int unsigned SetIndexBits   = 6;
   localparam int unsigned WayIndexBits   = 3;
   localparam int unsigned LineOffsetBits = 7;
   localparam int unsigned VictimTagBits  = 25;

   // lookup sequencer states
   typedef enum logic {
      ST_IDLE,
      ST_LOOKUP
   } lookup_state_type;

endpackage

/* hw/rtl/tagl_row_ram.sv */
module tagl_row_ram #(
   parameter int unsigned ROW_W  = 8,
   parameter int unsigned ADDR_W = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [ROW_W-1:0]  rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [ROW_W-1:0]  wr_data
);

   localparam int unsigned DEPTH = 1 << ADDR_W;

   logic [ROW_W-1:0] rows_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [ROW_W-1:0] rd_data_ff;
   logic             rd_valid_ff;

   // row storage, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rows_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= rows_ff[rd_addr];
      end
   end

   // per-row written flags, a row never written reads as all zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

/* hw/rtl/tagl_lookup.sv */
module tagl_lookup #(
   parameter int unsigned WAYS_LOG2       = tagl_pkg::DefWaysLog2,
   parameter int unsigned LINE_BYTES_LOG2 = tagl_pkg::DefLineBytesLog2,
   parameter int unsigned SETS_LOG2       = tagl_pkg::DefSetsLog2,
   parameter int unsigned ADDR_BITS       = tagl_pkg::DefAddrBits,
   localparam int unsigned NUM_WAYS = 1 << WAYS_LOG2,
   localparam int unsigned TAG_BITS = ADDR_BITS - LINE_BYTES_LOG2,
   localparam int unsigned WAY_W    = (WAYS_LOG2 > 0) ? WAYS_LOG2 : 1,
   localparam int unsigned SET_W    = (SETS_LOG2 > 0) ? SETS_LOG2 : 1,
   localparam int unsigned ROW_W    = NUM_WAYS * TAG_BITS
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // request channel
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic [ADDR_BITS-1:0]                      req_address,
   // response channel
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic                                      rsp_hit,
   output logic [tagl_pkg::SetIndexBits-1:0]         rsp_set_index,
   output logic [tagl_pkg::WayIndexBits-1:0]         rsp_way_index,
   output logic [tagl_pkg::LineOffsetBits-1:0]       rsp_line_offset,
   output logic [tagl_pkg::VictimTagBits-1:0]        rsp_victim_tag,
   // tag row memory
   output logic                                      tag_rd_en,
   output logic [SET_W-1:0]                          tag_rd_addr,
   input  logic [ROW_W-1:0]                          tag_rd_data,
   output logic                                      tag_wr_en,
   output logic [SET_W-1:0]                          tag_wr_addr,
   output logic [ROW_W-1:0]                          tag_wr_data,
   // replacement pointer memory
   output logic                                      ptr_rd_en,
   output logic [SET_W-1:0]                          ptr_rd_addr,
   input  logic [WAY_W-1:0]                          ptr_rd_data,
   output logic                                      ptr_wr_en,
   output logic [SET_W-1:0]                          ptr_wr_addr,
   output logic [WAY_W-1:0]                          ptr_wr_data
);

   localparam int unsigned EXT_W = TAG_BITS + SET_W;
   localparam logic [WAY_W-1:0] WAY_MASK = WAY_W'(NUM_WAYS - 1);

   tagl_pkg::lookup_state_type state_ff, state_in;

   logic [ADDR_BITS-1:0] addr_ff;
   logic                 accept;
   logic                 rsp_take;

   logic                 rsp_valid_ff;
   logic                 hit_ff;
   logic [tagl_pkg::SetIndexBits-1:0]   set_index_ff;
   logic [tagl_pkg::WayIndexBits-1:0]   way_index_ff;
   logic [tagl_pkg::LineOffsetBits-1:0] line_offset_ff;
   logic [tagl_pkg::VictimTagBits-1:0]  victim_tag_ff;

   logic [TAG_BITS-1:0]        req_tag;
   logic [EXT_W-1:0]           req_tag_ext;
   logic [SET_W-1:0]           req_set;
   logic [TAG_BITS-1:0]        cur_tag;
   logic [EXT_W-1:0]           cur_tag_ext;
   logic [SET_W-1:0]           cur_set;
   logic [LINE_BYTES_LOG2-1:0] cur_offset;

   logic                 found;
   logic [WAY_W-1:0]     match_way;
   logic [WAY_W-1:0]     victim_way;
   logic [WAY_W-1:0]     result_way;
   logic [TAG_BITS-1:0]  victim_tag;
   logic [ROW_W-1:0]     new_row;

   // address split for the incoming request and the held one
   always_comb begin
      req_tag     = req_address[ADDR_BITS-1:LINE_BYTES_LOG2];
      req_tag_ext = EXT_W'(req_tag);
      req_set     = (SETS_LOG2 > 0) ? req_tag_ext[SET_W-1:0] : '0;
      cur_tag     = addr_ff[ADDR_BITS-1:LINE_BYTES_LOG2];
      cur_tag_ext = EXT_W'(cur_tag);
      cur_set     = (SETS_LOG2 > 0) ? cur_tag_ext[SET_W-1:0] : '0;
      cur_offset  = addr_ff[LINE_BYTES_LOG2-1:0];
   end

   // compare all ways of the set, lowest matching way wins
   always_comb begin
      found     = 1'b0;
      match_way = '0;
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (tag_rd_data[w*TAG_BITS +: TAG_BITS] == cur_tag) begin
            found     = 1'b1;
            match_way = WAY_W'(w);
         end
      end
   end

   // fifo victim selection and row update on a miss
   always_comb begin
      victim_way = ptr_rd_data & WAY_MASK;
      victim_tag = '0;
      new_row    = tag_rd_data;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (WAY_W'(w) == victim_way) begin
            victim_tag                      = tag_rd_data[w*TAG_BITS +: TAG_BITS];
            new_row[w*TAG_BITS +: TAG_BITS] = cur_tag;
         end
      end
      result_way = found ? match_way : victim_way;
   end

   assign rsp_take = rsp_valid_ff && !rsp_stall;

   // sequencer: next state, stall and memory controls
   always_comb begin
      state_in    = state_ff;
      req_stall   = 1'b1;
      accept      = 1'b0;
      tag_wr_en   = 1'b0;
      ptr_wr_en   = 1'b0;
      unique case (state_ff)
         tagl_pkg::ST_IDLE: begin
            req_stall = rsp_valid_ff && rsp_stall;
            accept    = req_valid && !req_stall;
            if (accept) begin
               state_in = tagl_pkg::ST_LOOKUP;
            end
         end
         tagl_pkg::ST_LOOKUP: begin
            tag_wr_en = !found;
            ptr_wr_en = !found;
            state_in  = tagl_pkg::ST_IDLE;
         end
         default: begin
            state_in = tagl_pkg::ST_IDLE;
         end
      endcase
   end

   assign tag_rd_en   = accept;
   assign tag_rd_addr = req_set;
   assign ptr_rd_en   = accept;
   assign ptr_rd_addr = req_set;
   assign tag_wr_addr = cur_set;
   assign tag_wr_data = new_row;
   assign ptr_wr_addr = cur_set;
   assign ptr_wr_data = WAY_W'(victim_way + WAY_W'(1)) & WAY_MASK;

   // state and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tagl_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == tagl_pkg::ST_LOOKUP) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // held address and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff <= req_address;
      end
      if (state_ff == tagl_pkg::ST_LOOKUP) begin
         hit_ff         <= found;
         set_index_ff   <= tagl_pkg::SetIndexBits'(cur_set);
         way_index_ff   <= tagl_pkg::WayIndexBits'(result_way);
         line_offset_ff <= tagl_pkg::LineOffsetBits'(cur_offset);
         victim_tag_ff  <= found ? '0 : tagl_pkg::VictimTagBits'(victim_tag);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = hit_ff;
   assign rsp_set_index   = set_index_ff;
   assign rsp_way_index   = way_index_ff;
   assign rsp_line_offset = line_offset_ff;
   assign rsp_victim_tag  = victim_tag_ff;

endmodule

/* hw/rtl/set_assoc_tag_lookup_fifo.sv */
// A request transfer moves the sequencer from idle to lookup, which registers the response
// valid and payload. The tag row read is issued at the transfer, then compared and written
// back on a miss in the next cycle, with one lookup in flight: requests are stalled in the
// lookup state and while a valid response is stalled.
// Reset (synchronous, active high) clears the sequencer, the response valid and the
// per-set written flags, so every tag reads as zero and every pointer as way zero.
module set_assoc_tag_lookup_fifo #(
   parameter int unsigned WAYS_LOG2       = tagl_pkg::DefWaysLog2,
   parameter int unsigned LINE_BYTES_LOG2 = tagl_pkg::DefLineBytesLog2,
   parameter int unsigned SETS_LOG2       = tagl_pkg::DefSetsLog2,
   parameter int unsigned ADDR_BITS       = tagl_pkg::DefAddrBits
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ADDR_BITS-1:0]                req_address,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_hit,
   output logic [tagl_pkg::SetIndexBits-1:0]   rsp_set_index,
   output logic [tagl_pkg::WayIndexBits-1:0]   rsp_way_index,
   output logic [tagl_pkg::LineOffsetBits-1:0] rsp_line_offset,
   output logic [tagl_pkg::VictimTagBits-1:0]  rsp_victim_tag
);

   localparam int unsigned NUM_WAYS = 1 << WAYS_LOG2;
   localparam int unsigned TAG_BITS = ADDR_BITS - LINE_BYTES_LOG2;
   localparam int unsigned WAY_W    = (WAYS_LOG2 > 0) ? WAYS_LOG2 : 1;
   localparam int unsigned SET_W    = (SETS_LOG2 > 0) ? SETS_LOG2 : 1;
   localparam int unsigned ROW_W    = NUM_WAYS * TAG_BITS;

   logic             tag_rd_en;
   logic [SET_W-1:0] tag_rd_addr;
   logic [ROW_W-1:0] tag_rd_data;
   logic             tag_wr_en;
   logic [SET_W-1:0] tag_wr_addr;
   logic [ROW_W-1:0] tag_wr_data;
   logic             ptr_rd_en;
   logic [SET_W-1:0] ptr_rd_addr;
   logic [WAY_W-1:0] ptr_rd_data;
   logic             ptr_wr_en;
   logic [SET_W-1:0] ptr_wr_addr;
   logic [WAY_W-1:0] ptr_wr_data;

   // lookup sequencer and compare
   tagl_lookup #(
      .WAYS_LOG2       (WAYS_LOG2),
      .LINE_BYTES_LOG2 (LINE_BYTES_LOG2),
      .SETS_LOG2       (SETS_LOG2),
      .ADDR_BITS       (ADDR_BITS)
   ) u_lookup (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_address     (req_address),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_set_index   (rsp_set_index),
      .rsp_way_index   (rsp_way_index),
      .rsp_line_offset (rsp_line_offset),
      .rsp_victim_tag  (rsp_victim_tag),
      .tag_rd_en       (tag_rd_en),
      .tag_rd_addr     (tag_rd_addr),
      .tag_rd_data     (tag_rd_data),
      .tag_wr_en       (tag_wr_en),
      .tag_wr_addr     (tag_wr_addr),
      .tag_wr_data     (tag_wr_data),
      .ptr_rd_en       (ptr_rd_en),
      .ptr_rd_addr     (ptr_rd_addr),
      .ptr_rd_data     (ptr_rd_data),
      .ptr_wr_en       (ptr_wr_en),
      .ptr_wr_addr     (ptr_wr_addr),
      .ptr_wr_data     (ptr_wr_data)
   );

   // tag rows, all ways of one set per row
   tagl_row_ram #(
      .ROW_W  (ROW_W),
      .ADDR_W (SET_W)
   ) u_tag_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (tag_rd_en),
      .rd_addr (tag_rd_addr),
      .rd_data (tag_rd_data),
      .wr_en   (tag_wr_en),
      .wr_addr (tag_wr_addr),
      .wr_data (tag_wr_data)
   );

   // per-set fifo replacement pointers
   tagl_row_ram #(
      .ROW_W  (WAY_W),
      .ADDR_W (SET_W)
   ) u_ptr_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (ptr_rd_en),
      .rd_addr (ptr_rd_addr),
      .rd_data (ptr_rd_data),
      .wr_en   (ptr_wr_en),
      .wr_addr (ptr_wr_addr),
      .wr_data (ptr_wr_data)
   );

endmodule

/* hw/rtl/tagl_checker.sv */
module tagl_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic                                rsp_hit,
   input logic [tagl_pkg::SetIndexBits-1:0]   rsp_set_index,
   input logic [tagl_pkg::WayIndexBits-1:0]   rsp_way_index,
   input logic [tagl_pkg::LineOffsetBits-1:0] rsp_line_offset,
   input logic [tagl_pkg::VictimTagBits-1:0]  rsp_victim_tag
);

   // a stalled response holds its valid and payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_set_index)
         && $stable(rsp_way_index) && $stable(rsp_line_offset) && $stable(rsp_victim_tag))
      else $error("stalled response changed");

   // one lookup in flight: the cycle after a request transfer is stalled
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while lookup busy");

   // every request transfer yields a response once the lookup state has registered it
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> ##2 rsp_valid)
      else $error("response missing after request");

   // a hit evicts nothing
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_victim_tag == '0)
      else $error("victim tag nonzero on hit");

   // reset empties the response register
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind set_assoc_tag_lookup_fifo tagl_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_hit         (rsp_hit),
   .rsp_set_index   (rsp_set_index),
   .rsp_way_index   (rsp_way_index),
   .rsp_line_offset (rsp_line_offset),
   .rsp_victim_tag  (rsp_victim_tag)
);

/* bench/tag_lookup_check.sv */
module tag_lookup_check (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [tagl_pkg::DefAddrBits-1:0]    req_address,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic                                rsp_hit,
   input  logic [tagl_pkg::SetIndexBits-1:0]   rsp_set_index,
   input  logic [tagl_pkg::WayIndexBits-1:0]   rsp_way_index,
   input  logic [tagl_pkg::LineOffsetBits-1:0] rsp_line_offset,
   input  logic [tagl_pkg::VictimTagBits-1:0]  rsp_victim_tag,
   output int                                  mismatches,
   output int                                  pending_count,
   output int                                  lookups_checked,
   output int                                  hits_seen,
   output int                                  misses_seen,
   output int                                  dirty_evictions
);

   localparam int ADDR_W   = tagl_pkg::DefAddrBits;
   localparam int OFFS_W   = tagl_pkg::DefLineBytesLog2;
   localparam int SET_W    = tagl_pkg::DefSetsLog2;
   localparam int TAG_W    = tagl_pkg::DefAddrBits - tagl_pkg::DefLineBytesLog2;
   localparam int NUM_SETS = 1 << tagl_pkg::DefSetsLog2;
   localparam int NUM_WAYS = 1 << tagl_pkg::DefWaysLog2;

   typedef struct packed {
      logic                                hit;
      logic [tagl_pkg::SetIndexBits-1:0]   set_index;
      logic [tagl_pkg::WayIndexBits-1:0]   way_index;
      logic [tagl_pkg::LineOffsetBits-1:0] line_offset;
      logic [tagl_pkg::VictimTagBits-1:0]  victim_tag;
   } lookup_result_type;

   // shadow copy of the tag directory and per-set replacement pointers
   logic [TAG_W-1:0]                  tag_dir [NUM_SETS][NUM_WAYS];
   logic [tagl_pkg::WayIndexBits-1:0] replace_ptr [NUM_SETS];
   lookup_result_type                 pending_lookups [$];

   int n_fail;
   int n_checked;
   int n_hit;
   int n_miss;
   int n_dirty;

   // lookup one address, replacing in insertion order on a miss
   function automatic lookup_result_type predict_lookup(input logic [ADDR_W-1:0] addr);
      logic [TAG_W-1:0]  line_tag;
      logic [SET_W-1:0]  set_sel;
      lookup_result_type r;
      bit                found;
      line_tag      = addr[ADDR_W-1:OFFS_W];
      set_sel       = line_tag[SET_W-1:0];
      found         = 1'b0;
      r             = '0;
      r.set_index   = set_sel;
      r.line_offset = addr[OFFS_W-1:0];
      // scan downward so the lowest matching way wins
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (tag_dir[set_sel][w] == line_tag) begin
            found       = 1'b1;
            r.way_index = tagl_pkg::WayIndexBits'(w);
         end
      end
      r.hit = found;
      if (!found) begin
         r.way_index                      = replace_ptr[set_sel];
         r.victim_tag                     = tag_dir[set_sel][r.way_index];
         tag_dir[set_sel][r.way_index]    = line_tag;
         replace_ptr[set_sel]             = r.way_index + 1'b1;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      lookup_result_type want;
      lookup_result_type got;
      if (reset) begin
         foreach (tag_dir[s, w]) tag_dir[s][w] = '0;
         foreach (replace_ptr[s]) replace_ptr[s] = '0;
         pending_lookups.delete();
         n_fail    = 0;
         n_checked = 0;
         n_hit     = 0;
         n_miss    = 0;
         n_dirty   = 0;
      end else begin
         // response transfer: compare against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            got.hit         = rsp_hit;
            got.set_index   = rsp_set_index;
            got.way_index   = rsp_way_index;
            got.line_offset = rsp_line_offset;
            got.victim_tag  = rsp_victim_tag;
            if (pending_lookups.size() == 0) begin
               n_fail++;
               if (n_fail <= 10)
                  $display("%0t unexpected response: hit=%0d set=%0d way=%0d offset=%0d victim=%h",
                           $time, got.hit, got.set_index, got.way_index, got.line_offset,
                           got.victim_tag);
            end else begin
               want = pending_lookups.pop_front();
               n_checked++;
               if (want !== got) begin
                  n_fail++;
                  if (n_fail <= 10) begin
                     $display("%0t mismatch exp: hit=%0d set=%0d way=%0d offset=%0d victim=%h",
                              $time, want.hit, want.set_index, want.way_index,
                              want.line_offset, want.victim_tag);
                     $display("%0t mismatch got: hit=%0d set=%0d way=%0d offset=%0d victim=%h",
                              $time, got.hit, got.set_index, got.way_index,
                              got.line_offset, got.victim_tag);
                  end
               end
            end
         end
         // request transfer: predict and queue the result
         if (req_valid && !req_stall) begin
            want = predict_lookup(req_address);
            pending_lookups.push_back(want);
            if (want.hit) n_hit++;
            else begin
               n_miss++;
               if (want.victim_tag != '0) n_dirty++;
            end
         end
      end
      mismatches      <= n_fail;
      pending_count   <= pending_lookups.size();
      lookups_checked <= n_checked;
      hits_seen       <= n_hit;
      misses_seen     <= n_miss;
      dirty_evictions <= n_dirty;
   end

endmodule

/* bench/set_assoc_tag_lookup_fifo_test.sv */
module set_assoc_tag_lookup_fifo_test;

   localparam int ADDR_W         = tagl_pkg::DefAddrBits;
   localparam int OFFS_W         = tagl_pkg::DefLineBytesLog2;
   localparam int SET_W          = tagl_pkg::DefSetsLog2;
   localparam int HIGH_W         = tagl_pkg::DefAddrBits - tagl_pkg::DefLineBytesLog2
                                   - tagl_pkg::DefSetsLog2;
   localparam int RANDOM_LOOKUPS = 1950;
   localparam int POOL_SIZE      = 12;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 8;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_SPARSE,
      STALL_PERIODIC,
      STALL_HEAVY
   } stall_mode_type;

   logic                                clock       = 1'b0;
   logic                                reset       = 1'b1;
   logic                                req_valid   = 1'b0;
   logic [ADDR_W-1:0]                   req_address = '0;
   logic                                rsp_stall   = 1'b0;
   logic                                req_stall;
   logic                                rsp_valid;
   logic                                rsp_hit;
   logic [tagl_pkg::SetIndexBits-1:0]   rsp_set_index;
   logic [tagl_pkg::WayIndexBits-1:0]   rsp_way_index;
   logic [tagl_pkg::LineOffsetBits-1:0] rsp_line_offset;
   logic [tagl_pkg::VictimTagBits-1:0]  rsp_victim_tag;

   int mismatches;
   int pending_count;
   int lookups_checked;
   int hits_seen;
   int misses_seen;
   int dirty_evictions;

   logic [HIGH_W-1:0] tag_pool [POOL_SIZE];
   stall_mode_type    stall_mode  = STALL_NONE;
   int unsigned       stall_cycle = 0;
   int                idle_cycles = 0;

   always #1 clock = ~clock;

   set_assoc_tag_lookup_fifo uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_address     (req_address),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_set_index   (rsp_set_index),
      .rsp_way_index   (rsp_way_index),
      .rsp_line_offset (rsp_line_offset),
      .rsp_victim_tag  (rsp_victim_tag)
   );

   tag_lookup_check checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_address     (req_address),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_set_index   (rsp_set_index),
      .rsp_way_index   (rsp_way_index),
      .rsp_line_offset (rsp_line_offset),
      .rsp_victim_tag  (rsp_victim_tag),
      .mismatches      (mismatches),
      .pending_count   (pending_count),
      .lookups_checked (lookups_checked),
      .hits_seen       (hits_seen),
      .misses_seen     (misses_seen),
      .dirty_evictions (dirty_evictions)
   );

   // response stall pattern, switching to a random mode whenever the low six counter bits are zero
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall   <= 1'b0;
         stall_cycle <= 0;
         stall_mode  <= STALL_NONE;
      end else begin
         stall_cycle <= stall_cycle + 1;
         if (stall_cycle[5:0] == 6'd0)
            stall_mode <= stall_mode_type'($urandom_range(0, 3));
         case (stall_mode)
            STALL_NONE:     rsp_stall <= 1'b0;
            STALL_SPARSE:   rsp_stall <= ($urandom_range(0, 2) == 0);
            STALL_PERIODIC: rsp_stall <= (stall_cycle % 5 < 2);
            default:        rsp_stall <= ($urandom_range(0, 4) != 0);
         endcase
      end
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL set_assoc_tag_lookup_fifo");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // mostly a reused working set of tags so that hits and evictions both occur
   function automatic logic [ADDR_W-1:0] random_address();
      int unsigned       pick;
      logic [HIGH_W-1:0] high;
      pick = $urandom_range(0, 99);
      if (pick >= 70)
         return ADDR_W'($urandom);
      high = (pick < 60) ? tag_pool[$urandom_range(0, POOL_SIZE - 1)] : '0;
      return {high, SET_W'($urandom_range(0, (1 << SET_W) - 1)),
              OFFS_W'($urandom_range(0, (1 << OFFS_W) - 1))};
   endfunction

   // one request transfer, opening a new burst after a random gap when due
   task automatic send_lookup(input logic [ADDR_W-1:0] addr, inout int burst_left);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_address <= addr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   initial begin
      logic [ADDR_W-1:0] directed_addrs [$];
      int                burst_left;
      burst_left = 0;
      foreach (tag_pool[i]) tag_pool[i] = HIGH_W'($urandom);

      // zero tags hit after reset, lowest of several matching ways
      directed_addrs.push_back(32'h0000_0000);
      directed_addrs.push_back(32'h0000_007F);
      directed_addrs.push_back(32'hFFFF_FFFF);
      directed_addrs.push_back(32'hFFFF_FF80);
      directed_addrs.push_back(32'h8000_0000);
      directed_addrs.push_back(32'h0000_0000);
      // nine tags into one set: pointer wraps and a real tag is evicted
      for (int k = 1; k <= 9; k++)
         directed_addrs.push_back({19'(k), 6'd5, 7'(k)});
      directed_addrs.push_back({19'd1, 6'd5, 7'd0});
      directed_addrs.push_back({19'd9, 6'd5, 7'd127});
      directed_addrs.push_back(32'h7FFF_FFFF);
      directed_addrs.push_back(32'h5555_5555);
      directed_addrs.push_back(32'hAAAA_AAAA);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_addrs[i]) send_lookup(directed_addrs[i], burst_left);
      repeat (RANDOM_LOOKUPS) send_lookup(random_address(), burst_left);
      req_valid <= 1'b0;

      // let the pending count catch up with the last request transfer
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d lookups: %0d hits, %0d misses (%0d evicted a nonzero tag)",
               lookups_checked, hits_seen, misses_seen, dirty_evictions);
      $display("directed reset-tag, multi-match and pointer-wrap cases plus random traffic");
      if (mismatches == 0 && pending_count == 0)
         $display("PASS set_assoc_tag_lookup_fifo");
      else
         $display("FAIL set_assoc_tag_lookup_fifo");
      $finish;
   end

endmodule
